// ===== hdl/mtc_pkg.sv =====
// Shared types, character codes and Morse code tables for the Morse text codec.
`timescale 1ns / 1ps
package mtc_pkg;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_Z     = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CASE_GAP = 8'h20;

	localparam int ROM_SYMS = 5;
	localparam int LETTERS  = 26;
	localparam logic [5:0] CODE_NONE = 6'h3F;

	// One queued output run: optional leading char, symbols, optional trailing char.
	typedef struct packed {
		logic       lead_en;
		logic [7:0] lead_char;
		logic [2:0] sym_len;
		logic [4:0] sym_bits;
		logic       tail_en;
		logic [7:0] tail_char;
	} job_t;

	// Code word: [7:5] length, [4:0] symbols, first in bit 0, 1 = dash.
	function automatic logic [7:0] stock_word(input logic [5:0] idx);
		logic [7:0] w;
		case (idx)
			6'd0:  w = 8'h42;
			6'd1:  w = 8'h81;
			6'd2:  w = 8'h85;
			6'd3:  w = 8'h61;
			6'd4:  w = 8'h20;
			6'd5:  w = 8'h84;
			6'd6:  w = 8'h63;
			6'd7:  w = 8'h80;
			6'd8:  w = 8'h40;
			6'd9:  w = 8'h8E;
			6'd10: w = 8'h65;
			6'd11: w = 8'h82;
			6'd12: w = 8'h43;
			6'd13: w = 8'h41;
			6'd14: w = 8'h67;
			6'd15: w = 8'h86;
			6'd16: w = 8'h8B;
			6'd17: w = 8'h62;
			6'd18: w = 8'h60;
			6'd19: w = 8'h21;
			6'd20: w = 8'h64;
			6'd21: w = 8'h88;
			6'd22: w = 8'h66;
			6'd23: w = 8'h89;
			6'd24: w = 8'h8D;
			6'd25: w = 8'h83;
			6'd26: w = 8'hBF;
			6'd27: w = 8'hBE;
			6'd28: w = 8'hBC;
			6'd29: w = 8'hB8;
			6'd30: w = 8'hB0;
			6'd31: w = 8'hA0;
			6'd32: w = 8'hA1;
			6'd33: w = 8'hA3;
			6'd34: w = 8'hA7;
			6'd35: w = 8'hAF;
			default: w = 8'h00;
		endcase
		return w;
	endfunction

	// Reverse lookup: code word to table index, CODE_NONE when unknown.
	function automatic logic [5:0] code_index(input logic [7:0] key);
		logic [5:0] i;
		case (key)
			8'h42: i = 6'd0;
			8'h81: i = 6'd1;
			8'h85: i = 6'd2;
			8'h61: i = 6'd3;
			8'h20: i = 6'd4;
			8'h84: i = 6'd5;
			8'h63: i = 6'd6;
			8'h80: i = 6'd7;
			8'h40: i = 6'd8;
			8'h8E: i = 6'd9;
			8'h65: i = 6'd10;
			8'h82: i = 6'd11;
			8'h43: i = 6'd12;
			8'h41: i = 6'd13;
			8'h67: i = 6'd14;
			8'h86: i = 6'd15;
			8'h8B: i = 6'd16;
			8'h62: i = 6'd17;
			8'h60: i = 6'd18;
			8'h21: i = 6'd19;
			8'h64: i = 6'd20;
			8'h88: i = 6'd21;
			8'h66: i = 6'd22;
			8'h89: i = 6'd23;
			8'h8D: i = 6'd24;
			8'h83: i = 6'd25;
			8'hBF: i = 6'd26;
			8'hBE: i = 6'd27;
			8'hBC: i = 6'd28;
			8'hB8: i = 6'd29;
			8'hB0: i = 6'd30;
			8'hA0: i = 6'd31;
			8'hA1: i = 6'd32;
			8'hA3: i = 6'd33;
			8'hA7: i = 6'd34;
			8'hAF: i = 6'd35;
			default: i = CODE_NONE;
		endcase
		return i;
	endfunction

endpackage

// ===== hdl/mtc_queue.sv =====
// Two-entry job queue between the front classifier and the back emitter.
`timescale 1ns / 1ps
module mtc_queue
	import mtc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic nonempty,
	output job_t head_job
);

	job_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full     = (count_q == 2'd2);
	assign nonempty = (count_q != 2'd0);
	assign head_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

// ===== hdl/mtc_front.sv =====
// Front end: accepts input bytes, tracks decode state and builds output jobs.
`timescale 1ns / 1ps
module mtc_front
	import mtc_pkg::*;
#(
	parameter int MAX_SYMBOLS   = 5,
	parameter int TABLE_ENTRIES = 36
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       mode,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       q_full,
	output logic       push,
	output job_t       job
);

	localparam int CW = $clog2(MAX_SYMBOLS + 1);

	logic [4:0]    bits_q, bits_n;
	logic [CW-1:0] cnt_q, cnt_n;
	logic          bad_q, bad_n;
	logic          accept;
	logic [7:0]    up;
	logic [5:0]    letter_idx;
	logic [7:0]    word;
	logic [2:0]    len;
	logic [7:0]    key;
	logic [5:0]    hit;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign push     = accept && (job.lead_en || job.tail_en || (job.sym_len != 3'd0));

	always_comb begin
		job        = '0;
		bits_n     = bits_q;
		cnt_n      = cnt_q;
		bad_n      = bad_q;
		up         = in_byte;
		letter_idx = 6'd0;
		word       = 8'h00;
		len        = 3'd0;
		key        = {cnt_q[2:0], bits_q};
		hit        = code_index(key);
		if (in_byte inside {[CH_LA:CH_LZ]}) begin
			up = in_byte - CASE_GAP;
		end
		if (!mode) begin
			if (up inside {[CH_A:CH_Z]}) begin
				letter_idx = 6'(up - CH_A);
				word       = stock_word(letter_idx);
				len        = word[7:5];
				if (len > 3'(ROM_SYMS)) begin
					len = 3'(ROM_SYMS);
				end
				job.sym_len   = len;
				job.sym_bits  = word[4:0];
				job.tail_en   = 1'b1;
				job.tail_char = CH_SPACE;
			end else if (in_byte == CH_SPACE) begin
				job.lead_en   = 1'b1;
				job.lead_char = CH_SLASH;
				job.tail_en   = 1'b1;
				job.tail_char = CH_SPACE;
			end else if (in_byte == CH_NL) begin
				job.tail_en   = 1'b1;
				job.tail_char = CH_NL;
			end
		end else begin
			if (in_byte inside {CH_DOT, CH_DASH}) begin
				if (cnt_q >= CW'(MAX_SYMBOLS)) begin
					bad_n = 1'b1;
				end else begin
					if ((cnt_q < CW'(ROM_SYMS)) && (in_byte == CH_DASH)) begin
						bits_n[cnt_q[2:0]] = 1'b1;
					end
					cnt_n = cnt_q + CW'(1);
				end
			end else if (in_byte inside {CH_SPACE, CH_SLASH, CH_NL, CH_NUL}) begin
				if (!bad_q && (cnt_q != '0) && (cnt_q <= CW'(ROM_SYMS)) && (hit != CODE_NONE)
						&& ({1'b0, hit} < 7'(TABLE_ENTRIES))) begin
					job.lead_en = 1'b1;
					if ({1'b0, hit} < 7'(LETTERS)) begin
						job.lead_char = CH_A + {2'b00, hit};
					end else begin
						job.lead_char = CH_ZERO + {2'b00, hit - 6'(LETTERS)};
					end
				end
				if (in_byte == CH_SLASH) begin
					job.tail_en   = 1'b1;
					job.tail_char = CH_SPACE;
				end else if (in_byte == CH_NL) begin
					job.tail_en   = 1'b1;
					job.tail_char = CH_NL;
				end
				bits_n = 5'd0;
				cnt_n  = '0;
				bad_n  = 1'b0;
			end else begin
				bad_n = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= 5'd0;
			cnt_q  <= '0;
			bad_q  <= 1'b0;
		end else if (accept && mode) begin
			bits_q <= bits_n;
			cnt_q  <= cnt_n;
			bad_q  <= bad_n;
		end
	end

endmodule

// ===== hdl/mtc_back.sv =====
// Back end: plays queued jobs into the output register, one byte per unstalled cycle.
`timescale 1ns / 1ps
module mtc_back
	import mtc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_nonempty,
	input  job_t       q_head,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       last_of_run
);

	logic       cur_valid_q;
	logic       lead_en_q;
	logic [7:0] lead_char_q;
	logic [2:0] syms_q;
	logic [4:0] bits_q;
	logic       tail_en_q;
	logic [7:0] tail_char_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       last_q;

	logic       out_free;
	logic       emit;
	logic [7:0] emit_char;
	logic       lead_en_n;
	logic [2:0] syms_n;
	logic [4:0] bits_n;
	logic       tail_en_n;
	logic       emit_last;

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = last_q;

	assign out_free = !out_valid_q || !out_stall;
	assign emit     = cur_valid_q && out_free;
	assign q_pop    = q_nonempty && (!cur_valid_q || (emit && emit_last));

	always_comb begin
		lead_en_n = lead_en_q;
		syms_n    = syms_q;
		bits_n    = bits_q;
		tail_en_n = tail_en_q;
		if (lead_en_q) begin
			emit_char = lead_char_q;
			lead_en_n = 1'b0;
		end else if (syms_q != 3'd0) begin
			emit_char = bits_q[0] ? CH_DASH : CH_DOT;
			syms_n    = syms_q - 3'd1;
			bits_n    = {1'b0, bits_q[4:1]};
		end else begin
			emit_char = tail_char_q;
			tail_en_n = 1'b0;
		end
		emit_last = !lead_en_n && (syms_n == 3'd0) && !tail_en_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			lead_en_q   <= 1'b0;
			syms_q      <= 3'd0;
			tail_en_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				cur_valid_q <= 1'b1;
				lead_en_q   <= q_head.lead_en;
				syms_q      <= q_head.sym_len;
				tail_en_q   <= q_head.tail_en;
			end else if (emit) begin
				cur_valid_q <= !emit_last;
				lead_en_q   <= lead_en_n;
				syms_q      <= syms_n;
				tail_en_q   <= tail_en_n;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			lead_char_q <= q_head.lead_char;
			bits_q      <= q_head.sym_bits;
			tail_char_q <= q_head.tail_char;
		end else if (emit) begin
			bits_q <= bits_n;
		end
		if (emit) begin
			out_byte_q <= emit_char;
			last_q     <= emit_last;
		end
	end

endmodule

// ===== hdl/morse_text_codec_unit.sv =====
// Top level of the Morse text codec: configuration port, front end, job queue and back end.
`timescale 1ns / 1ps
// Takes one input byte per cycle while the two-entry job queue has room; each byte's output
// run (zero to six bytes) leaves the back end at one byte per cycle while the output is not
// stalled. A result passes through the queue slot, the back end's current-job registers and
// the output register.
// Register 0 (mode) at address 0: 0 encodes, 1 decodes; change it only while the block is
// idle. Gathered decode state survives a mode change.
module morse_text_codec_unit
	import mtc_pkg::*;
#(
	parameter int MAX_SYMBOLS   = 5,
	parameter int TABLE_ENTRIES = 36
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        last_of_run
);

	logic mode_q;
	logic q_full;
	logic q_push;
	job_t push_job;
	logic q_pop;
	logic q_nonempty;
	job_t head_job;
	logic addr_hit;

	// Single register: every address in the window maps to mode.
	assign addr_hit = (paddr[1:0] == paddr[1:0]);
	assign pready   = 1'b1;
	assign prdata   = {31'd0, mode_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (psel && penable && pwrite && addr_hit) begin
			mode_q <= pwdata[0];
		end
	end

	mtc_front #(
		.MAX_SYMBOLS  (MAX_SYMBOLS),
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.mode    (mode_q),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte (in_byte),
		.q_full  (q_full),
		.push    (q_push),
		.job     (push_job)
	);

	mtc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_job(push_job),
		.full    (q_full),
		.pop     (q_pop),
		.nonempty(q_nonempty),
		.head_job(head_job)
	);

	mtc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_head     (head_job),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.last_of_run(last_of_run)
	);

endmodule

// ===== sim/morse_text_codec_unit_tb.sv =====
// Self-checking testbench for morse_text_codec_unit: encode and decode streams vs. a codec model.
`timescale 1ns / 1ps
module morse_text_codec_unit_tb;
	import mtc_pkg::*;

	localparam int         MAX_SYMS     = 5;
	localparam int         TABLE_N      = 36;
	localparam logic [1:0] MODE_ADDR    = 2'd0;
	localparam logic       MODE_ENCODE  = 1'b0;
	localparam logic       MODE_DECODE  = 1'b1;
	localparam int         DRAIN_CYCLES = 16;
	localparam int         HOLD_CYCLES  = 200;
	localparam int         STUCK_LIMIT  = 2000;

	// Morse words, entry 0 in the low byte: [7:5] length, [4:0] symbols, first in bit 0.
	localparam logic [TABLE_N*8-1:0] MORSE_WORDS = {
		8'hAF, 8'hA7, 8'hA3, 8'hA1, 8'hA0, 8'hB0, 8'hB8, 8'hBC, 8'hBE, 8'hBF,
		8'h83, 8'h8D, 8'h89, 8'h66, 8'h88, 8'h64, 8'h21, 8'h60, 8'h62, 8'h8B,
		8'h86, 8'h67, 8'h41, 8'h43, 8'h82, 8'h65, 8'h8E, 8'h40, 8'h80, 8'h63,
		8'h84, 8'h20, 8'h61, 8'h85, 8'h81, 8'h42
	};

	typedef struct {
		logic [7:0] ch;
		logic       last;
	} out_char_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  in_byte;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  out_byte;
	logic        last_of_run;

	out_char_t   pending_chars [$];
	out_char_t   due;
	int          mismatches;
	int          items_sent;
	logic        gaps_on;
	logic        hold_req;

	// codec model state
	logic        mode_q;
	logic [4:0]  sym_bits_q;
	logic [2:0]  sym_cnt_q;
	logic        code_bad_q;

	always #5 clk = ~clk;

	morse_text_codec_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_byte     (in_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.last_of_run (last_of_run)
	);

	function automatic logic [7:0] morse_word(input int idx);
		return MORSE_WORDS[idx*8 +: 8];
	endfunction

	// Advance the codec model by one input byte and queue the characters it produces.
	task automatic predict_codec(input logic [7:0] b);
		logic [7:0] run_chars [0:7];
		logic [7:0] up;
		logic [7:0] w;
		logic [7:0] key;
		int         n;
		int         len;
		logic       hit;
		out_char_t  oc;
		n = 0;
		hit = 1'b0;
		if (mode_q == MODE_ENCODE) begin
			up = (b >= CH_LA && b <= CH_LZ) ? b - CASE_GAP : b;
			if (up >= CH_A && up <= CH_Z) begin
				w = morse_word(int'(up - CH_A));
				len = int'(w[7:5]);
				if (len > ROM_SYMS)
					len = ROM_SYMS;
				for (int k = 0; k < len; k++) begin
					run_chars[n] = w[k] ? CH_DASH : CH_DOT;
					n++;
				end
				run_chars[n] = CH_SPACE;
				n++;
			end else if (b == CH_SPACE) begin
				run_chars[0] = CH_SLASH;
				run_chars[1] = CH_SPACE;
				n = 2;
			end else if (b == CH_NL) begin
				run_chars[0] = CH_NL;
				n = 1;
			end
		end else begin
			if (b == CH_DOT || b == CH_DASH) begin
				if (sym_cnt_q >= MAX_SYMS) begin
					code_bad_q = 1'b1;
				end else begin
					if (b == CH_DASH && sym_cnt_q < ROM_SYMS)
						sym_bits_q[sym_cnt_q] = 1'b1;
					sym_cnt_q++;
				end
			end else if (b == CH_SPACE || b == CH_SLASH || b == CH_NL || b == CH_NUL) begin
				if (!code_bad_q && sym_cnt_q > 0 && sym_cnt_q <= ROM_SYMS) begin
					key = {sym_cnt_q, sym_bits_q};
					for (int i = 0; i < TABLE_N; i++) begin
						if (!hit && morse_word(i) == key) begin
							hit = 1'b1;
							run_chars[n] = 8'((i < LETTERS) ? CH_A + i
									: CH_ZERO + (i - LETTERS));
							n++;
						end
					end
				end
				if (b == CH_SLASH) begin
					run_chars[n] = CH_SPACE;
					n++;
				end else if (b == CH_NL) begin
					run_chars[n] = CH_NL;
					n++;
				end
				sym_bits_q = '0;
				sym_cnt_q = '0;
				code_bad_q = 1'b0;
			end else begin
				code_bad_q = 1'b1;
			end
		end
		for (int i = 0; i < n; i++) begin
			oc.ch = run_chars[i];
			oc.last = (i == n - 1);
			pending_chars.push_back(oc);
		end
	endtask

	task automatic send_byte(input logic [7:0] b);
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 99) < 8) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		do @(posedge clk); while (in_stall);
		predict_codec(b);
		items_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// Stop offering input, wait for every queued character, then let no-output bytes settle.
	task automatic drain_pipeline();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_mode(input logic m);
		drain_pipeline();
		write_reg(MODE_ADDR, {31'd0, m});
		mode_q = m;
	endtask

	task automatic send_code(input logic [7:0] w);
		for (int k = 0; k < int'(w[7:5]); k++)
			send_byte(w[k] ? CH_DASH : CH_DOT);
	endtask

	function automatic logic [7:0] pick_terminator();
		case ($urandom_range(0, 3))
			0: return CH_SPACE;
			1: return CH_SLASH;
			2: return CH_NL;
			default: return CH_NUL;
		endcase
	endfunction

	task automatic test_encode_edges();
		set_mode(MODE_ENCODE);
		send_text("AzQy \n");
		send_byte(CH_NUL);
		send_byte(8'hFF);
		send_text("@[`{7");
	endtask

	task automatic test_decode_edges();
		set_mode(MODE_DECODE);
		send_text("-----\n");
		send_text("..--/");
		send_text("...... ");
		send_text(".x");
		send_byte(CH_NUL);
		send_text(" -");
		send_byte(CH_NUL);
	endtask

	// decode state gathered before a switch to encode must survive it
	task automatic test_mode_keeps_code();
		set_mode(MODE_DECODE);
		send_text(".-");
		set_mode(MODE_ENCODE);
		send_text("e");
		set_mode(MODE_DECODE);
		send_text(" ");
	endtask

	task automatic test_encode_random(input int count);
		int    stop_at;
		int    r;
		logic [7:0] c;
		stop_at = items_sent + count;
		set_mode(MODE_ENCODE);
		while (items_sent < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				c = CH_A + 8'($urandom_range(0, 25));
				send_byte($urandom_range(0, 1) ? c + CASE_GAP : c);
			end else if (r < 70) begin
				send_byte(CH_SPACE);
			end else if (r < 78) begin
				send_byte(CH_NL);
			end else begin
				send_byte(8'($urandom_range(0, 255)));
			end
		end
	endtask

	task automatic test_decode_random(input int count);
		int stop_at;
		int r;
		int len;
		stop_at = items_sent + count;
		set_mode(MODE_DECODE);
		while (items_sent < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 65) begin
				send_code(morse_word($urandom_range(0, TABLE_N - 1)));
			end else if (r < 80) begin
				len = $urandom_range(1, 7);
				for (int k = 0; k < len; k++)
					send_byte($urandom_range(0, 1) ? CH_DASH : CH_DOT);
			end else if (r < 92) begin
				send_code(morse_word($urandom_range(0, TABLE_N - 1)));
				send_byte(8'($urandom_range(0, 255)));
			end
			send_byte(pick_terminator());
		end
	endtask

	task automatic test_decode_streaming(input int count);
		gaps_on = 1'b0;
		test_decode_random(count);
		drain_pipeline();
		gaps_on = 1'b1;
	endtask

	// receiver holds off while letters keep coming, so the input side has to stall
	task automatic test_output_holdoff(input int count);
		set_mode(MODE_ENCODE);
		hold_req = 1'b1;
		for (int i = 0; i < count; i++)
			send_byte(CH_LA + 8'($urandom_range(0, 25)));
	endtask

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			out_stall <= gaps_on && ($urandom_range(0, 99) < 8);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_chars.size() == 0) begin
				$error("unexpected transaction: out_byte %h last_of_run %b", out_byte,
					last_of_run);
				mismatches++;
			end else begin
				due = pending_chars.pop_front();
				if (out_byte !== due.ch) begin
					$error("out_byte: expected %h, got %h", due.ch, out_byte);
					mismatches++;
				end
				if (last_of_run !== due.last) begin
					$error("last_of_run: expected %b, got %b", due.last, last_of_run);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int stuck;
		stuck = 0;
		while (stuck < STUCK_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				stuck = 0;
			else
				stuck++;
		end
		$display("morse_text_codec_unit_tb failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		in_byte = '0;
		gaps_on = 1'b1;
		hold_req = 1'b0;
		mismatches = 0;
		items_sent = 0;
		mode_q = MODE_ENCODE;
		sym_bits_q = '0;
		sym_cnt_q = '0;
		code_bad_q = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_encode_edges();
		test_decode_edges();
		test_mode_keeps_code();
		test_encode_random(90);
		test_decode_random(110);
		test_decode_streaming(50);
		test_output_holdoff(30);
		drain_pipeline();

		if (mismatches == 0)
			$display("morse_text_codec_unit_tb passed");
		else
			$display("morse_text_codec_unit_tb failed");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/mtc_pkg.sv
hdl/mtc_queue.sv
hdl/mtc_front.sv
hdl/mtc_back.sv
hdl/morse_text_codec_unit.sv
sim/morse_text_codec_unit_tb.sv
